// ===== rtl/srpc_pkg.sv =====
// Package with shared constants, command codes and control types of the servo ramp controller.
`timescale 1ns / 1ps

package srpc_pkg;

	// Number of joints held in the block.
	localparam int NUM_JOINTS = 4;
	// Joints that have a position field in the result word.
	localparam int REPORTED_JOINTS = 4;
	// Width of a joint select that addresses the joint state.
	localparam int JSEL_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	// Field widths.
	localparam int CMD_W = 2;
	localparam int JIDX_W = 4;
	localparam int POS_W = 8;
	localparam int DUR_W = 26;
	localparam int LPU_W = 8;
	localparam int IV_W = 32;
	localparam int MASK_W = 4;

	// Stream word layout.
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int MOV_LSB = REPORTED_JOINTS * POS_W;
	localparam int FIN_LSB = MOV_LSB + MASK_W;

	// Divider sizes: product of loops and duration, divided by twice the distance.
	localparam int PROD_W = LPU_W + DUR_W;
	localparam int DEN_W = POS_W + 1;
	localparam int DCNT_W = $clog2(PROD_W);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GOTO = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_LOOPS_PER_US = 2'd0;
	localparam logic [1:0] REG_MIN_STEP = 2'd1;
	localparam logic [1:0] REG_POS_MIN = 2'd2;
	localparam logic [1:0] REG_POS_MAX = 2'd3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// Reset values.
	localparam logic [LPU_W-1:0] LPU_RST = 8'd26;
	localparam logic [IV_W-1:0] MIN_STEP_RST = 32'd5000;
	localparam logic [POS_W-1:0] POS_MIN_RST = 8'd8;
	localparam logic [POS_W-1:0] POS_MAX_RST = 8'd160;
	localparam logic [POS_W-1:0] JOINT_POS_RST = 8'd8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_start;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_stat_t;

endpackage

// ===== rtl/srpc_div.sv =====
// Bit-serial restoring divider for the ramp step interval.
`timescale 1ns / 1ps

module srpc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [srpc_pkg::PROD_W-1:0] dividend,
	input  logic [srpc_pkg::DEN_W-1:0]  divisor,
	output logic                       done,
	output logic [srpc_pkg::PROD_W-1:0] quotient
);
	import srpc_pkg::*;

	logic                running_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [PROD_W-1:0]   quo_q;
	logic [DEN_W:0]      trial;
	logic                fits;

	// One quotient bit per cycle: shift the next dividend bit into the remainder.
	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		fits = (trial >= {1'b0, den_q});
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			cnt_q <= DCNT_W'(PROD_W - 1);
		end else if (running_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == '0) begin
				running_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (running_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign done = !running_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/srpc_datapath.sv =====
// Datapath: configuration registers, joint state, step logic, divider and result register.
`timescale 1ns / 1ps

module srpc_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  srpc_pkg::ctrl_cmd_t                cmd,
	output srpc_pkg::dp_stat_t                 stat,
	input  logic [srpc_pkg::CMD_W-1:0]         in_command,
	input  logic [srpc_pkg::IN_TDATA_W-1:0]    in_data,
	input  logic                               cfg_we,
	input  logic [srpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic                               out_status,
	output logic [srpc_pkg::OUT_TDATA_W-1:0]   out_data
);
	import srpc_pkg::*;

	// Configuration registers.
	logic [LPU_W-1:0] lpu_q;
	logic [IV_W-1:0]  min_step_q;
	logic [POS_W-1:0] pos_min_q;
	logic [POS_W-1:0] pos_max_q;

	// Held input item.
	logic [CMD_W-1:0]  cmd_q;
	logic [JIDX_W-1:0] joint_q;
	logic [POS_W-1:0]  tpos_q;
	logic [DUR_W-1:0]  dur_q;

	// Joint state.
	logic [POS_W-1:0] pos_q [NUM_JOINTS];
	logic [POS_W-1:0] tgt_q [NUM_JOINTS];
	logic [IV_W-1:0]  iv_q [NUM_JOINTS];
	logic [IV_W-1:0]  cnt_q [NUM_JOINTS];
	logic [NUM_JOINTS-1:0] mov_q;

	// Next state.
	logic [POS_W-1:0] pos_n [NUM_JOINTS];
	logic [POS_W-1:0] tgt_n [NUM_JOINTS];
	logic [IV_W-1:0]  iv_n [NUM_JOINTS];
	logic [IV_W-1:0]  cnt_n [NUM_JOINTS];
	logic [NUM_JOINTS-1:0] mov_n;
	logic [NUM_JOINTS-1:0] fin_n;

	logic [JSEL_W-1:0] jsel;
	logic              jvalid;
	logic [POS_W-1:0]  cur_pos;
	logic [POS_W-1:0]  pos_dist;
	logic              bad;
	logic              div_done;
	logic [PROD_W-1:0] quo;
	logic [IV_W-1:0]   q_sat;
	logic [IV_W-1:0]   ramp_iv;
	logic [IV_W:0]     cnt_inc;
	logic [OUT_TDATA_W-1:0] rep_data;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpu_q <= LPU_RST;
			min_step_q <= MIN_STEP_RST;
			pos_min_q <= POS_MIN_RST;
			pos_max_q <= POS_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOOPS_PER_US: lpu_q <= cfg_wdata[LPU_W-1:0];
				REG_MIN_STEP: min_step_q <= cfg_wdata[IV_W-1:0];
				REG_POS_MIN: pos_min_q <= cfg_wdata[POS_W-1:0];
				REG_POS_MAX: pos_max_q <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input word capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			joint_q <= in_data[JIDX_W-1:0];
			tpos_q <= in_data[JIDX_W +: POS_W];
			dur_q <= in_data[JIDX_W+POS_W +: DUR_W];
		end
	end

	// Request check and distance of the addressed joint.
	always_comb begin
		jsel = joint_q[JSEL_W-1:0];
		jvalid = (joint_q < JIDX_W'(NUM_JOINTS));
		cur_pos = pos_q[jsel];
		pos_dist = (tpos_q > cur_pos) ? (tpos_q - cur_pos) : (cur_pos - tpos_q);
		bad = (cmd_q == CMD_BAD) ||
			((cmd_q != CMD_TICK) &&
			(!jvalid || (tpos_q < pos_min_q) || (tpos_q > pos_max_q)));
	end

	assign stat.need_div = (cmd_q == CMD_GOTO) && !bad && (pos_dist != '0);
	assign stat.div_done = div_done;

	// Interval divider: loops times duration over twice the distance.
	srpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (PROD_W'(lpu_q) * PROD_W'(dur_q)),
		.divisor  ({1'b0, pos_dist} << 1),
		.done     (div_done),
		.quotient (quo)
	);

	// Saturate the quotient and raise it to the smallest allowed interval.
	always_comb begin
		q_sat = (quo[PROD_W-1:IV_W] != '0) ? '1 : quo[IV_W-1:0];
		ramp_iv = (q_sat < min_step_q) ? min_step_q : q_sat;
	end

	// Next joint state for the held item.
	always_comb begin
		pos_n = pos_q;
		tgt_n = tgt_q;
		iv_n = iv_q;
		cnt_n = cnt_q;
		mov_n = mov_q;
		fin_n = '0;
		cnt_inc = '0;
		if (cmd_q == CMD_TICK) begin
			for (int k = 0; k < NUM_JOINTS; k++) begin
				cnt_inc = {1'b0, cnt_q[k]} + (IV_W+1)'(1);
				if (mov_q[k]) begin
					if (cnt_inc >= {1'b0, iv_q[k]}) begin
						cnt_n[k] = '0;
						if (pos_q[k] < tgt_q[k]) begin
							pos_n[k] = pos_q[k] + POS_W'(1);
						end else if (pos_q[k] > tgt_q[k]) begin
							pos_n[k] = pos_q[k] - POS_W'(1);
						end
						if (pos_n[k] == tgt_q[k]) begin
							mov_n[k] = 1'b0;
							fin_n[k] = 1'b1;
						end
					end else begin
						cnt_n[k] = cnt_inc[IV_W-1:0];
					end
				end
			end
		end else if (!bad) begin
			if (cmd_q == CMD_SET) begin
				pos_n[jsel] = tpos_q;
				tgt_n[jsel] = tpos_q;
				mov_n[jsel] = 1'b0;
				cnt_n[jsel] = '0;
			end else begin
				tgt_n[jsel] = tpos_q;
				cnt_n[jsel] = '0;
				if (pos_dist == '0) begin
					mov_n[jsel] = 1'b0;
					fin_n[jsel] = 1'b1;
				end else begin
					iv_n[jsel] = ramp_iv;
					mov_n[jsel] = 1'b1;
				end
			end
		end
	end

	// Joint state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_JOINTS; k++) begin
				pos_q[k] <= JOINT_POS_RST;
				tgt_q[k] <= JOINT_POS_RST;
				iv_q[k] <= '0;
				cnt_q[k] <= '0;
			end
			mov_q <= '0;
		end else if (cmd.commit) begin
			pos_q <= pos_n;
			tgt_q <= tgt_n;
			iv_q <= iv_n;
			cnt_q <= cnt_n;
			mov_q <= mov_n;
		end
	end

	// Result word: reported positions, moving mask and finished mask.
	always_comb begin
		rep_data = '0;
		for (int k = 0; k < REPORTED_JOINTS; k++) begin
			if (k < NUM_JOINTS) begin
				rep_data[k*POS_W +: POS_W] = pos_n[JSEL_W'(k)];
			end
		end
		for (int k = 0; k < MASK_W; k++) begin
			if (k < NUM_JOINTS) begin
				rep_data[MOV_LSB + k] = mov_n[JSEL_W'(k)];
				rep_data[FIN_LSB + k] = fin_n[JSEL_W'(k)];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status <= bad;
			out_data <= rep_data;
		end
	end

endmodule

// ===== rtl/srpc_ctrl.sv =====
// Controller state machine: input handshake, divider sequencing and output valid.
`timescale 1ns / 1ps

module srpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  srpc_pkg::dp_stat_t  stat,
	output srpc_pkg::ctrl_cmd_t cmd
);
	import srpc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.need_div) begin
					cmd.div_start = 1'b1;
					state_n = ST_DIV;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (stat.div_done && out_free) begin
					cmd.commit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/servo_position_ramp_controller.sv =====
// Top level of the four-joint servo position ramp controller.
`timescale 1ns / 1ps

// Takes one command word at a time and returns one result word for it. A tick, a set
// pose or a rejected request is captured on acceptance and committed to the result
// register from the execute state. A goto pose with a nonzero distance first computes
// its step interval in a bit-serial divider, one quotient bit per cycle over the
// 34-bit product of loops_per_us and duration_us. A new word is accepted while the
// previous result still waits in the output register; the result is committed once
// that register is free. There is no clearing pass after reset.
module servo_position_ramp_controller
	import srpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Input word.
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// Fields from bit 0: joint_index[3:0], target_position[11:4], duration_us[37:12].
	input  logic [IN_TDATA_W-1:0]    s_tdata,
	// Fields: command[1:0].
	input  logic [CMD_W-1:0]         s_tuser,
	// Result word.
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// Fields from bit 0: position_joint0..3 (8 bits each), moving_mask[35:32],
	// finished_mask[39:36].
	output logic [OUT_TDATA_W-1:0]   m_tdata,
	// Fields: status[0].
	output logic                     m_tuser,
	// Configuration write port.
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequencing.
	srpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Joint state and arithmetic.
	srpc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_tuser),
		.in_data    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_status (m_tuser),
		.out_data   (m_tdata)
	);

endmodule

// ===== rtl/srpc_checker.sv =====
// Port checker for the servo ramp controller and its bind statement.
`timescale 1ns / 1ps

module srpc_checker
	import srpc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// One word at a time: no acceptance right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// A rejected request finishes no ramp.
	a_reject_no_fin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[FIN_LSB +: MASK_W] == '0)
		else $error("finished bits on a rejected request");

	// A joint that finished is no longer moving.
	a_fin_not_moving: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[FIN_LSB +: MASK_W] & m_tdata[MOV_LSB +: MASK_W]) == '0)
		else $error("joint both finished and moving");

endmodule

bind servo_position_ramp_controller srpc_checker u_srpc_checker (.*);

// ===== bench/tb_servo_position_ramp_controller.sv =====
// Testbench for the servo position ramp controller: random and directed command words checked against a local model.
`timescale 1ns / 1ps

module tb_servo_position_ramp_controller;
	import srpc_pkg::*;

	// Cycles without any stream transfer or configuration write before the run is declared hung.
	localparam int HANG_LIMIT = 4000;
	// Cycles allowed after the last result for stray words to show up.
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [JIDX_W-1:0] joint;
		logic [POS_W-1:0]  pos;
		logic [DUR_W-1:0]  dur;
	} servo_cmd_t;

	typedef struct packed {
		logic                                  status;
		logic [REPORTED_JOINTS-1:0][POS_W-1:0] pos;
		logic [MASK_W-1:0]                     moving;
		logic [MASK_W-1:0]                     finished;
	} ramp_result_t;

	typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_EVERY8} ready_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Mirror of the configuration registers.
	logic [LPU_W-1:0] cfg_lpu = LPU_RST;
	logic [IV_W-1:0]  cfg_min_step = MIN_STEP_RST;
	logic [POS_W-1:0] cfg_pos_min = POS_MIN_RST;
	logic [POS_W-1:0] cfg_pos_max = POS_MAX_RST;

	// Model copy of the joint state.
	logic [POS_W-1:0] model_pos [NUM_JOINTS] = '{default: JOINT_POS_RST};
	logic [POS_W-1:0] model_tgt [NUM_JOINTS] = '{default: JOINT_POS_RST};
	logic [IV_W-1:0]  model_iv [NUM_JOINTS] = '{default: '0};
	logic [IV_W-1:0]  model_cnt [NUM_JOINTS] = '{default: '0};
	logic             model_moving [NUM_JOINTS] = '{default: 1'b0};

	servo_cmd_t   commands_pending[$];
	ramp_result_t ramp_results_due[$];
	servo_cmd_t   cmd_on_bus;
	int           mismatches = 0;
	int           burst_left = 8;
	int           gap_left = 0;
	ready_mode_t  ready_mode = RDY_ALWAYS;
	int           mode_left = 50;
	int           ready_phase = 0;
	int           quiet_cycles = 0;

	servo_position_ramp_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one command word to the model state and returns the result word it produces.
	function automatic ramp_result_t compute_ramp_result(input servo_cmd_t c);
		ramp_result_t r;
		logic [63:0]  prod;
		logic [63:0]  quo;
		logic [POS_W-1:0] pos_dist;
		int           j;
		r = '0;
		j = int'(c.joint);
		if (c.cmd == CMD_TICK) begin
			for (int k = 0; k < NUM_JOINTS; k++) begin
				if (model_moving[k]) begin
					if ({1'b0, model_cnt[k]} + 33'd1 >= {1'b0, model_iv[k]}) begin
						model_cnt[k] = '0;
						if (model_pos[k] < model_tgt[k])
							model_pos[k] = model_pos[k] + 1'b1;
						else if (model_pos[k] > model_tgt[k])
							model_pos[k] = model_pos[k] - 1'b1;
						if (model_pos[k] == model_tgt[k]) begin
							model_moving[k] = 1'b0;
							if (k < MASK_W)
								r.finished[k] = 1'b1;
						end
					end else begin
						model_cnt[k] = model_cnt[k] + 1'b1;
					end
				end
			end
		end else if (c.cmd == CMD_BAD || j >= NUM_JOINTS || c.pos < cfg_pos_min ||
				c.pos > cfg_pos_max) begin
			r.status = 1'b1;
		end else if (c.cmd == CMD_SET) begin
			model_pos[j] = c.pos;
			model_tgt[j] = c.pos;
			model_moving[j] = 1'b0;
			model_cnt[j] = '0;
		end else begin
			// Goto: the step interval comes from the duration spread over the distance.
			pos_dist = (c.pos > model_pos[j]) ? c.pos - model_pos[j] : model_pos[j] - c.pos;
			model_tgt[j] = c.pos;
			model_cnt[j] = '0;
			if (pos_dist == '0) begin
				model_moving[j] = 1'b0;
				r.finished[j] = 1'b1;
			end else begin
				prod = 64'(cfg_lpu) * 64'(c.dur);
				quo = prod / (64'(pos_dist) * 64'd2);
				model_iv[j] = (quo > 64'hFFFF_FFFF) ? '1 : quo[IV_W-1:0];
				if (model_iv[j] < cfg_min_step)
					model_iv[j] = cfg_min_step;
				model_moving[j] = 1'b1;
			end
		end
		for (int k = 0; k < NUM_JOINTS; k++)
			if (k < MASK_W && model_moving[k])
				r.moving[k] = 1'b1;
		for (int k = 0; k < REPORTED_JOINTS; k++)
			if (k < NUM_JOINTS)
				r.pos[k] = model_pos[k];
		return r;
	endfunction

	// Draws one command word; most are ticks and well-formed requests that keep ramps short.
	function automatic servo_cmd_t random_command();
		servo_cmd_t c;
		int sel;
		int lo;
		int hi;
		int whi;
		lo = int'(cfg_pos_min);
		hi = int'(cfg_pos_max);
		c.joint = JIDX_W'($urandom_range(0, NUM_JOINTS - 1));
		c.dur = DUR_W'($urandom);
		if (lo <= hi) begin
			whi = (lo + 15 < hi) ? lo + 15 : hi;
			c.pos = POS_W'(($urandom_range(0, 9) < 7) ? $urandom_range(lo, whi) :
				$urandom_range(lo, hi));
		end else begin
			c.pos = POS_W'($urandom);
		end
		sel = $urandom_range(0, 99);
		if (sel < 62) begin
			c.cmd = CMD_TICK;
			c.joint = JIDX_W'($urandom);
			c.pos = POS_W'($urandom);
		end else if (sel < 80) begin
			c.cmd = CMD_GOTO;
			if ($urandom_range(0, 4) != 0)
				c.dur = DUR_W'(($urandom_range(0, 4) * 2 * $urandom_range(1, 16)) /
					int'(cfg_lpu));
		end else if (sel < 88) begin
			c.cmd = CMD_SET;
		end else begin
			c.cmd = CMD_W'($urandom_range(0, 3));
			c.joint = JIDX_W'($urandom);
			c.pos = POS_W'($urandom);
		end
		return c;
	endfunction

	task automatic push_word(input logic [CMD_W-1:0] cmd, input int joint, input int pos,
			input int dur);
		servo_cmd_t c;
		c.cmd = cmd;
		c.joint = JIDX_W'(joint);
		c.pos = POS_W'(pos);
		c.dur = DUR_W'(dur);
		commands_pending.push_back(c);
	endtask

	task automatic push_random(input int count);
		for (int n = 0; n < count; n++)
			commands_pending.push_back(random_command());
	endtask

	// Waits until every word has been sent and every result has come back.
	task automatic wait_idle();
		while (commands_pending.size() != 0 || s_tvalid || ramp_results_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_LOOPS_PER_US: cfg_lpu = val[LPU_W-1:0];
			REG_MIN_STEP:     cfg_min_step = val[IV_W-1:0];
			REG_POS_MIN:      cfg_pos_min = val[POS_W-1:0];
			default:          cfg_pos_max = val[POS_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_config(input int lpu, input logic [31:0] min_step, input int pmin,
			input int pmax);
		write_reg(REG_LOOPS_PER_US, lpu);
		write_reg(REG_MIN_STEP, min_step);
		write_reg(REG_POS_MIN, pmin);
		write_reg(REG_POS_MAX, pmax);
	endtask

	// Stimulus sequence: directed checks, then random phases under several settings.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: range edges, rejected requests, stop and restart of ramps.
		push_word(CMD_TICK, 0, 0, 0);
		push_word(CMD_SET, 0, 8, 0);
		push_word(CMD_SET, 1, 160, 0);
		push_word(CMD_SET, 2, 7, 0);
		push_word(CMD_SET, 3, 161, 0);
		push_word(CMD_SET, 4, 50, 0);
		push_word(CMD_GOTO, 15, 50, 0);
		push_word(CMD_BAD, 0, 50, 0);
		push_word(CMD_BAD, 15, 255, 67108863);
		push_word(CMD_GOTO, 0, 8, 100);
		push_word(CMD_GOTO, 1, 20, 67108863);
		push_word(CMD_TICK, 15, 255, 67108863);
		push_word(CMD_GOTO, 1, 30, 0);
		push_word(CMD_SET, 1, 12, 0);
		push_word(CMD_GOTO, 2, 9, 0);
		push_word(CMD_TICK, 0, 0, 0);
		push_random(80);
		wait_idle();

		// Fastest stepping: zero interval moves a joint on every tick.
		write_config(1, 32'd0, 0, 255);
		@(negedge clk);
		push_word(CMD_SET, 0, 0, 0);
		push_word(CMD_SET, 3, 255, 0);
		push_word(CMD_GOTO, 0, 3, 0);
		push_word(CMD_GOTO, 3, 253, 4);
		repeat (4) push_word(CMD_TICK, 0, 0, 0);
		push_random(250);
		wait_idle();

		write_config(255, 32'd3, 20, 200);
		@(negedge clk);
		push_random(200);
		wait_idle();

		// Largest minimum interval: ramps started here never complete, zero-distance gotos still do.
		write_config($urandom_range(1, 255), 32'hFFFF_FFFF, 0, 255);
		@(negedge clk);
		push_random(100);
		wait_idle();

		// Empty position range: every set and goto is rejected.
		write_config(26, 32'd1, 255, 0);
		@(negedge clk);
		push_random(70);
		wait_idle();

		write_config(3, 32'd2, 8, 160);
		@(negedge clk);
		push_random(250);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Command driver: bursts of words separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				ramp_results_due.push_back(compute_ramp_result(cmd_on_bus));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (commands_pending.size() != 0) begin
					cmd_on_bus = commands_pending.pop_front();
					s_tdata <= {{(IN_TDATA_W - JIDX_W - POS_W - DUR_W){1'b0}},
						cmd_on_bus.dur, cmd_on_bus.pos, cmd_on_bus.joint};
					s_tuser <= cmd_on_bus.cmd;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Result monitor with its own back-pressure pattern.
	always @(posedge clk or negedge arst_n) begin
		ramp_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (ramp_results_due.size() == 0) begin
					$display("%0t: unexpected result word: expected none, actual %h status %b",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = ramp_results_due.pop_front();
					check_field("status", 32'(want.status), 32'(m_tuser));
					for (int k = 0; k < REPORTED_JOINTS; k++)
						check_field($sformatf("position_joint%0d", k), 32'(want.pos[k]),
							32'(m_tdata[k*POS_W +: POS_W]));
					check_field("moving_mask", 32'(want.moving),
						32'(m_tdata[MOV_LSB +: MASK_W]));
					check_field("finished_mask", 32'(want.finished),
						32'(m_tdata[FIN_LSB +: MASK_W]));
				end
			end
			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			ready_phase <= ready_phase + 1;
			case (ready_mode)
				RDY_ALWAYS: m_tready <= 1'b1;
				RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
				RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
				default:    m_tready <= (ready_phase % 8 == 0);
			endcase
		end
	end

	// Hang detector: ends the run when nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
